[design/nwa_pkg.sv]
// Package for the NFA word acceptance block: sizes, command codes, FSM states
// and the structs passed between the front and the back. No dependencies.
`default_nettype none
package nwa_pkg;

  localparam int NUM_STATES  = 16;
  localparam int SYMBOL_BITS = 8;
  localparam int STATE_BITS  = $clog2(NUM_STATES);
  localparam int TABLE_DEPTH = NUM_STATES * (2 ** SYMBOL_BITS);
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic CFG_INITIAL_STATE = 1'b0;
  localparam logic CFG_FINAL_MASK    = 1'b1;

  typedef logic [NUM_STATES-1:0] set_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_STEP,
    OP_END,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MERGE
  } back_state_e;

  typedef struct packed {
    op_e                    op;
    logic [STATE_BITS-1:0]  src;
    logic [SYMBOL_BITS-1:0] sym;
    set_t                   succ;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } front_req_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } back_rsp_t;

  typedef struct packed {
    logic [3:0]  initial_state;
    logic [15:0] final_mask;
  } cfg_t;

  function automatic set_t start_set(logic [3:0] init);
    set_t s;
    s = '0;
    if (32'(init) < NUM_STATES) begin
      s[init[STATE_BITS-1:0]] = 1'b1;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[design/nwa_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module nwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[design/nwa_front.sv]
// Front of the NFA block: accepts input items, classifies them into operations
// and holds them in a short queue for the back. Depends on nwa_pkg.
`default_nettype none
module nwa_front
  import nwa_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [1:0]             command_i,
  input  wire logic [3:0]             source_state_i,
  input  wire logic [7:0]             symbol_i,
  input  wire logic [15:0]            next_states_i,
  output front_req_t                  req_o,
  input  wire back_rsp_t              rsp_i
);

  cmd_t       slot_q [QUEUE_DEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_new;
  logic       accept, enq, deq;

  always_comb begin
    cmd_new.src  = source_state_i[STATE_BITS-1:0];
    cmd_new.sym  = symbol_i[SYMBOL_BITS-1:0];
    cmd_new.succ = next_states_i[NUM_STATES-1:0];
    unique case (command_i)
      CMD_WRITE: begin
        cmd_new.op = (32'(source_state_i) < NUM_STATES) ? OP_WRITE : OP_NOP;
      end
      CMD_STEP: cmd_new.op = OP_STEP;
      CMD_END:  cmd_new.op = OP_END;
      default:  cmd_new.op = OP_NOP;
    endcase
  end

  assign full   = (cnt_q == 2'(QUEUE_DEPTH)) || rsp_i.clearing;
  assign accept = push && !full;
  assign enq    = accept && (cmd_new.op != OP_NOP);
  assign deq    = rsp_i.take && (cnt_q != 2'd0);

  assign req_o.valid = (cnt_q != 2'd0);
  assign req_o.cmd   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (enq) begin
      slot_q[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (enq) begin
        wptr_q <= ~wptr_q;
      end
      if (deq) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(enq) - 2'(deq);
    end
  end

endmodule
`default_nettype wire

[design/nwa_back.sv]
// Back of the NFA block: clears and writes the transition table, steps the
// active state set and queues end-of-word results. Depends on nwa_pkg, nwa_ram.
`default_nettype none
module nwa_back
  import nwa_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire front_req_t   req_i,
  output back_rsp_t         rsp_o,
  input  wire cfg_t         cfg_i,
  output logic              empty,
  input  wire logic         pop,
  output logic              accepted_o,
  output logic [15:0]       active_states_o
);

  back_state_e            state_q, state_d;
  logic [TABLE_AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [STATE_BITS-1:0]  idx_q, idx_d;
  logic [SYMBOL_BITS-1:0] sym_q, sym_d;
  logic                   pend_q, pend_d;
  set_t                   acc_q, acc_d;
  set_t                   cur_q, cur_d;

  logic                   ram_we;
  logic [TABLE_AW-1:0]    ram_waddr, ram_raddr;
  set_t                   ram_wdata, ram_rdata;

  logic [16:0]            res_q [QUEUE_DEPTH];
  logic                   res_wptr_q, res_rptr_q;
  logic [1:0]             res_cnt_q;
  logic                   res_push, res_pop;
  logic [16:0]            res_new;

  nwa_ram #(
    .WIDTH(NUM_STATES),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d        = state_q;
    clr_cnt_d      = clr_cnt_q;
    idx_d          = idx_q;
    sym_d          = sym_q;
    pend_d         = pend_q;
    acc_d          = acc_q;
    cur_d          = cur_q;
    ram_we         = 1'b0;
    ram_waddr      = clr_cnt_q;
    ram_wdata      = '0;
    ram_raddr      = {idx_q, sym_q};
    rsp_o.take     = 1'b0;
    rsp_o.clearing = (state_q == ST_CLEAR);
    res_push       = 1'b0;
    res_new        = {((cur_q & cfg_i.final_mask[NUM_STATES-1:0]) != '0),
                      16'(cur_q)};
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + TABLE_AW'(1);
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (req_i.cmd.op)
            OP_WRITE: begin
              ram_we     = 1'b1;
              ram_waddr  = {req_i.cmd.src, req_i.cmd.sym};
              ram_wdata  = req_i.cmd.succ;
              rsp_o.take = 1'b1;
            end
            OP_STEP: begin
              rsp_o.take = 1'b1;
              sym_d      = req_i.cmd.sym;
              idx_d      = '0;
              pend_d     = 1'b0;
              acc_d      = '0;
              state_d    = ST_SCAN;
            end
            OP_END: begin
              if (res_cnt_q != 2'(QUEUE_DEPTH)) begin
                rsp_o.take = 1'b1;
                res_push   = 1'b1;
                cur_d      = start_set(cfg_i.initial_state);
              end
            end
            OP_NOP: rsp_o.take = 1'b1;
            default: rsp_o.take = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        pend_d = cur_q[idx_q];
        if (pend_q) begin
          acc_d = acc_q | ram_rdata;
        end
        idx_d = idx_q + STATE_BITS'(1);
        if (idx_q == STATE_BITS'(NUM_STATES - 1)) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cur_d   = acc_q | (pend_q ? ram_rdata : '0);
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      cur_q     <= start_set(4'd0);
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      cur_q     <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    sym_q  <= sym_d;
    pend_q <= pend_d;
    acc_q  <= acc_d;
  end

  assign empty           = (res_cnt_q == 2'd0);
  assign res_pop         = pop && !empty;
  assign accepted_o      = res_q[res_rptr_q][16];
  assign active_states_o = res_q[res_rptr_q][15:0];

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wptr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wptr_q <= 1'b0;
      res_rptr_q <= 1'b0;
      res_cnt_q  <= 2'd0;
    end else begin
      if (res_push) begin
        res_wptr_q <= ~res_wptr_q;
      end
      if (res_pop) begin
        res_rptr_q <= ~res_rptr_q;
      end
      res_cnt_q <= res_cnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

endmodule
`default_nettype wire

[design/nfa_word_acceptance.sv]
// Top level of the NFA word acceptance block: configuration registers and the
// front and back parts. Depends on nwa_pkg, nwa_front, nwa_back.
//
// Channel   Direction  Handshake        Payload
// input     in         push / full      command, source_state, symbol, next_states
// result    out        empty / pop      accepted, active_states
// config    in         cfg_we_i         cfg_index_i, cfg_data_i
//
// The back takes a table write or an end of word in its idle state; a word
// symbol is scanned with one table read per state from the single table memory.
// After reset a clearing pass zeroes all 4096 table entries; full is high
// throughout it, while configuration writes are still taken.
// Two-entry queues decouple the input side from the back and the back from
// the result side, so either side may stall without losing items.
`default_nettype none
module nfa_word_acceptance
  import nwa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  command_i,
  input  wire logic [3:0]  source_state_i,
  input  wire logic [7:0]  symbol_i,
  input  wire logic [15:0] next_states_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             accepted_o,
  output logic [15:0]      active_states_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t       cfg_q;
  front_req_t req;
  back_rsp_t  rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INITIAL_STATE: cfg_q.initial_state <= cfg_data_i[3:0];
        CFG_FINAL_MASK:    cfg_q.final_mask    <= cfg_data_i;
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  nwa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .command_i     (command_i),
    .source_state_i(source_state_i),
    .symbol_i      (symbol_i),
    .next_states_i (next_states_i),
    .req_o         (req),
    .rsp_i         (rsp)
  );

  nwa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .rsp_o          (rsp),
    .cfg_i          (cfg_q),
    .empty          (empty),
    .pop            (pop),
    .accepted_o     (accepted_o),
    .active_states_o(active_states_o)
  );

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for nfa_word_acceptance: table writes, word symbols and
// word ends, checked against a state-set predictor. Depends on nwa_pkg and the RTL.
module tb_top;
  import nwa_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         CYCLE_LIMIT  = 500000;
  localparam int         PHASE_ITEMS  = 310;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // For a configuration row, src carries the start state and succ the final mask.
  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] cmd;
    logic [3:0] src;
    logic [7:0] sym;
    set_t       succ;
    logic       typed;
    logic       acc;
    set_t       set;
  } stim_row_t;

  typedef struct packed {
    logic acc;
    set_t active;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  command_i = CMD_UNUSED;
  logic [3:0]  source_state_i = '0;
  logic [7:0]  symbol_i = '0;
  logic [15:0] next_states_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        accepted_o;
  logic [15:0] active_states_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_INITIAL_STATE;
  logic [15:0] cfg_data_i = '0;

  set_t       succ_table [TABLE_DEPTH];
  set_t       active_set;
  logic [3:0] start_state;
  set_t       accept_mask;
  verdict_t   pending_verdicts [$];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         tx_idle_pct = 33;
  int         rx_idle_pct = 64;

  stim_row_t directed [0:23] = '{
    '{ROW_ITEM, CMD_END,    4'h0, 8'h00, 16'h0000, 1'b1, 1'b0, 16'h0001},
    '{ROW_ITEM, CMD_UNUSED, 4'hF, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_END,    4'hF, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 16'h0001},
    '{ROW_ITEM, CMD_WRITE,  4'h0, 8'h00, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_WRITE,  4'hF, 8'hFF, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_WRITE,  4'h7, 8'h5A, 16'h8001, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_STEP,   4'h0, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_END,    4'h0, 8'h00, 16'h0000, 1'b1, 1'b0, 16'hFFFF},
    '{ROW_ITEM, CMD_STEP,   4'h0, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_STEP,   4'h0, 8'hFF, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_STEP,   4'h0, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_END,    4'h0, 8'h00, 16'h0000, 1'b1, 1'b0, 16'h0000},
    '{ROW_CFG,  CMD_UNUSED, 4'hF, 8'h00, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_END,    4'h0, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h0001},
    '{ROW_ITEM, CMD_END,    4'h0, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h8000},
    '{ROW_ITEM, CMD_WRITE,  4'hF, 8'h5A, 16'h0080, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_STEP,   4'h0, 8'h5A, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_STEP,   4'h0, 8'h5A, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_END,    4'h0, 8'h00, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_CFG,  CMD_UNUSED, 4'h0, 8'h00, 16'h8000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_END,    4'h0, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h8000},
    '{ROW_ITEM, CMD_WRITE,  4'h0, 8'hAA, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_STEP,   4'h0, 8'hAA, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, CMD_END,    4'h0, 8'h00, 16'h0000, 1'b1, 1'b0, 16'h0000}
  };

  nfa_word_acceptance u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .source_state_i  (source_state_i),
    .symbol_i        (symbol_i),
    .next_states_i   (next_states_i),
    .empty           (empty),
    .pop             (pop),
    .accepted_o      (accepted_o),
    .active_states_o (active_states_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic set_t start_states(logic [3:0] init);
    set_t s;
    s = '0;
    if (32'(init) < NUM_STATES) begin
      s[init] = 1'b1;
    end
    return s;
  endfunction

  function automatic void predict_item(input logic [1:0] cmd, input logic [3:0] src,
                                       input logic [7:0] sym, input set_t succ,
                                       output logic has_result, output verdict_t v);
    set_t nxt;
    nxt = '0;
    has_result = 1'b0;
    v = '0;
    case (cmd)
      CMD_WRITE: begin
        if (32'(src) < NUM_STATES) begin
          succ_table[{src, sym}] = succ;
        end
      end
      CMD_STEP: begin
        for (int s = 0; s < NUM_STATES; s++) begin
          if (active_set[s]) begin
            nxt |= succ_table[{4'(s), sym}];
          end
        end
        active_set = nxt;
      end
      CMD_END: begin
        has_result = 1'b1;
        v.acc = |(active_set & accept_mask);
        v.active = active_set;
        active_set = start_states(start_state);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [3:0] src,
                           input logic [7:0] sym, input set_t succ,
                           input logic typed, input logic t_acc, input set_t t_set);
    logic     has_result;
    verdict_t v;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    source_state_i <= src;
    symbol_i <= sym;
    next_states_i <= succ;
    do @(posedge clk_i); while (full);
    predict_item(cmd, src, sym, succ, has_result, v);
    if (has_result) begin
      pending_verdicts = {pending_verdicts, (typed ? verdict_t'({t_acc, t_set}) : v)};
    end
  endtask

  // Symbol items produce no result, so the back may still be busy once the
  // last result is in; the extra cycles cover a full queue of symbol steps.
  task automatic settle();
    push <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [3:0] init, input set_t mask);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_INITIAL_STATE;
    cfg_data_i <= {12'($urandom), init};
    @(posedge clk_i);
    start_state = init;
    cfg_index_i <= CFG_FINAL_MASK;
    cfg_data_i <= mask;
    @(posedge clk_i);
    accept_mask = mask;
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : result_side
    verdict_t want;
    if (pop && !empty) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result", 16'h0, active_states_o);
      end else begin
        want = pending_verdicts.pop_front();
        if (accepted_o !== want.acc) begin
          report_mismatch("accepted", 16'(want.acc), 16'(accepted_o));
        end
        if (active_states_o !== want.active) begin
          report_mismatch("active_states", want.active, active_states_o);
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin : stimulus
    int         counted;
    int         r;
    logic [1:0] cmd;
    logic [3:0] src;
    logic [7:0] sym;
    set_t       succ;
    foreach (succ_table[i]) succ_table[i] = '0;
    start_state = '0;
    accept_mask = '0;
    active_set = start_states(start_state);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle();
        write_regs(directed[i].src, directed[i].succ);
      end else begin
        send_item(directed[i].cmd, directed[i].src, directed[i].sym, directed[i].succ,
                  directed[i].typed, directed[i].acc, directed[i].set);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      settle();
      tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 64 : 0;
      rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 33 : 0;
      write_regs(4'($urandom), set_t'($urandom));
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        src = 4'($urandom);
        sym = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        // Mostly sparse successor sets, so that active sets do not saturate.
        if ($urandom_range(0, 3) == 0) begin
          succ = set_t'($urandom);
        end else begin
          succ = set_t'(1) << $urandom_range(0, 15);
          if ($urandom_range(0, 1) != 0) begin
            succ |= set_t'(1) << $urandom_range(0, 15);
          end
        end
        if (r < 30) begin
          cmd = CMD_WRITE;
        end else if (r < 82) begin
          cmd = CMD_STEP;
        end else if (r < 96) begin
          cmd = CMD_END;
        end else begin
          cmd = CMD_UNUSED;
        end
        send_item(cmd, src, sym, succ, 1'b0, 1'b0, '0);
        if (cmd != CMD_UNUSED) begin
          counted++;
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
